>>> sv/event_driven_gate_simulator_unit_defines.svh
// Assertion macros for the gate simulator checker.
`ifndef EVENT_DRIVEN_GATE_SIMULATOR_UNIT_DEFINES_SVH
`define EVENT_DRIVEN_GATE_SIMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define EDGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define EDGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> sv/edgs_pkg.sv
// Types, codes and gate evaluation helpers for the gate simulator.
package edgs_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_STIM  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_op_t;

	localparam logic [2:0] GT_AND  = 3'd0;
	localparam logic [2:0] GT_NAND = 3'd1;
	localparam logic [2:0] GT_OR   = 3'd2;
	localparam logic [2:0] GT_NOR  = 3'd3;
	localparam logic [2:0] GT_XOR  = 3'd4;
	localparam logic [2:0] GT_XNOR = 3'd5;
	localparam logic [2:0] GT_NOT  = 3'd6;

	localparam logic [1:0] LV_LOW  = 2'd0;
	localparam logic [1:0] LV_HIGH = 2'd1;
	localparam logic [1:0] LV_UNK  = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_LIMIT = 3'd2;
	localparam logic [2:0] ST_CFG   = 3'd3;
	localparam logic [2:0] ST_OVF   = 3'd4;

	localparam logic [19:0] EVENT_LIMIT_RESET = 20'd65535;

	typedef struct packed {
		cmd_op_t         op;
		logic [2:0]      kind;
		logic [2:0]      nin;
		logic [3:0][7:0] src;
		logic [7:0]      target;
		logic [15:0]     delay;
		logic [1:0]      level;
		logic [31:0]     time_ns;
		logic            load_bad;
		logic            stim_bad;
	} cmd_t;

	typedef struct packed {
		logic [2:0]      kind;
		logic [2:0]      nin;
		logic [3:0][7:0] src;
		logic [7:0]      dst;
		logic [15:0]     delay;
	} gate_t;

	typedef struct packed {
		logic [31:0] time_ns;
		logic [7:0]  net;
		logic [1:0]  level;
	} event_t;

	typedef struct packed {
		logic any_low;
		logic any_high;
		logic any_unk;
		logic parity;
	} eval_acc_t;

	typedef enum logic [3:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_LOAD,
		BS_SCAN,
		BS_SHRD,
		BS_SHWR,
		BS_COMMIT,
		BS_GCHK,
		BS_IN,
		BS_EVAL,
		BS_DONE
	} back_state_t;

	function automatic eval_acc_t acc_add(eval_acc_t a, logic [1:0] v);
		eval_acc_t r;
		r = a;
		if (v == LV_LOW) begin
			r.any_low = 1'b1;
		end else if (v == LV_HIGH) begin
			r.any_high = 1'b1;
			r.parity   = ~a.parity;
		end else begin
			r.any_unk = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [1:0] eval_level(logic [2:0] kind, eval_acc_t a);
		logic [1:0] r;
		case (kind)
			GT_AND:  r = a.any_low ? LV_LOW : (a.any_unk ? LV_UNK : LV_HIGH);
			GT_NAND: r = a.any_low ? LV_HIGH : (a.any_unk ? LV_UNK : LV_LOW);
			GT_OR:   r = a.any_high ? LV_HIGH : (a.any_unk ? LV_UNK : LV_LOW);
			GT_NOR:  r = a.any_high ? LV_LOW : (a.any_unk ? LV_UNK : LV_HIGH);
			GT_XOR:  r = a.any_unk ? LV_UNK : (a.parity ? LV_HIGH : LV_LOW);
			GT_XNOR: r = a.any_unk ? LV_UNK : (a.parity ? LV_LOW : LV_HIGH);
			GT_NOT:  r = a.any_low ? LV_HIGH : (a.any_high ? LV_LOW : LV_UNK);
			default: r = LV_UNK;
		endcase
		return r;
	endfunction

endpackage

>>> sv/event_driven_gate_simulator_unit.sv
// Load, stimulus and step commands end in the result register.
// A step scans the queued events for the earliest one and compacts the queue; if the net
// changes, it then checks each gate and re-evaluates each gate that reads the changed net.
// A clear sweeps the whole net memory; commands run one at a time.
// After reset the same net memory sweep runs before the first command is executed,
// while the two-entry command queue can still take commands.
module event_driven_gate_simulator_unit #(
	parameter int NUM_NETS    = 256,
	parameter int MAX_GATES   = 128,
	parameter int MAX_FANIN   = 4,
	parameter int QUEUE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  gate_type,
	input  logic [2:0]  fanin,
	input  logic [7:0]  in_net_a,
	input  logic [7:0]  in_net_b,
	input  logic [7:0]  in_net_c,
	input  logic [7:0]  in_net_d,
	input  logic [7:0]  target_net,
	input  logic [15:0] gate_delay,
	input  logic [1:0]  stim_level,
	input  logic [31:0] stim_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        trace_valid,
	output logic [31:0] trace_time,
	output logic [7:0]  trace_net,
	output logic [1:0]  trace_level
);

	logic [19:0]    event_limit_q;
	logic           push;
	logic           fifo_full;
	logic           fifo_ne;
	logic           pop;
	edgs_pkg::cmd_t front_item;
	edgs_pkg::cmd_t fifo_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_limit_q <= edgs_pkg::EVENT_LIMIT_RESET;
		end else if (cfg_we) begin
			event_limit_q <= cfg_wdata;
		end
	end

	edgs_front #(
		.NUM_NETS  (NUM_NETS),
		.MAX_FANIN (MAX_FANIN)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.gate_type  (gate_type),
		.fanin      (fanin),
		.in_net_a   (in_net_a),
		.in_net_b   (in_net_b),
		.in_net_c   (in_net_c),
		.in_net_d   (in_net_d),
		.target_net (target_net),
		.gate_delay (gate_delay),
		.stim_level (stim_level),
		.stim_time  (stim_time),
		.fifo_full  (fifo_full),
		.push       (push),
		.item       (front_item)
	);

	edgs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (front_item),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (fifo_ne),
		.rdata     (fifo_item)
	);

	edgs_back #(
		.NUM_NETS    (NUM_NETS),
		.MAX_GATES   (MAX_GATES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_limit (event_limit_q),
		.cmd_valid   (fifo_ne),
		.cmd         (fifo_item),
		.cmd_pop     (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.trace_valid (trace_valid),
		.trace_time  (trace_time),
		.trace_net   (trace_net),
		.trace_level (trace_level)
	);

endmodule

>>> sv/edgs_front.sv
// Front end: accepts commands and classifies the static load and stimulus checks.
module edgs_front #(
	parameter int NUM_NETS  = 256,
	parameter int MAX_FANIN = 4
) (
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       command,
	input  logic [2:0]       gate_type,
	input  logic [2:0]       fanin,
	input  logic [7:0]       in_net_a,
	input  logic [7:0]       in_net_b,
	input  logic [7:0]       in_net_c,
	input  logic [7:0]       in_net_d,
	input  logic [7:0]       target_net,
	input  logic [15:0]      gate_delay,
	input  logic [1:0]       stim_level,
	input  logic [31:0]      stim_time,
	input  logic             fifo_full,
	output logic             push,
	output edgs_pkg::cmd_t   item
);

	logic [3:0][7:0] nets;
	logic            bad;

	assign nets     = {in_net_d, in_net_c, in_net_b, in_net_a};
	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		bad = 1'b0;
		if (gate_type > edgs_pkg::GT_NOT) begin
			bad = 1'b1;
		end else if (gate_type == edgs_pkg::GT_NOT) begin
			if (fanin != 3'd1) bad = 1'b1;
		end else if (fanin < 3'd2 || 32'(fanin) > MAX_FANIN) begin
			bad = 1'b1;
		end
		if (gate_delay == 16'd0) bad = 1'b1;
		if (32'(target_net) >= NUM_NETS) bad = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (32'(i) < 32'(fanin) && 32'(nets[i]) >= NUM_NETS) bad = 1'b1;
		end

		item.op   = edgs_pkg::cmd_op_t'(command);
		item.kind = gate_type;
		item.nin  = fanin;
		for (int i = 0; i < 4; i++) begin
			item.src[i] = (32'(i) < 32'(fanin)) ? nets[i] : 8'd0;
		end
		item.target   = target_net;
		item.delay    = gate_delay;
		// Level code three is taken as unknown.
		item.level    = (stim_level == 2'd3) ? edgs_pkg::LV_UNK : stim_level;
		item.time_ns  = stim_time;
		item.load_bad = bad;
		item.stim_bad = 32'(target_net) >= NUM_NETS;
	end

endmodule

>>> sv/edgs_fifo.sv
// Two-entry command queue between the front end and the execution engine.
module edgs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  edgs_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output edgs_pkg::cmd_t rdata
);

	edgs_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rdata     = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

endmodule

>>> sv/edgs_back.sv
// Execution engine: net, gate and event memories, command sequencer, result register.
module edgs_back #(
	parameter int NUM_NETS    = 256,
	parameter int MAX_GATES   = 128,
	parameter int QUEUE_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [19:0]    event_limit,
	input  logic           cmd_valid,
	input  edgs_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     status,
	output logic           trace_valid,
	output logic [31:0]    trace_time,
	output logic [7:0]     trace_net,
	output logic [1:0]     trace_level
);

	localparam int NW  = $clog2(NUM_NETS);
	localparam int GW  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int GCW = $clog2(MAX_GATES + 1);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	// Net memory entry: driven flag and level.
	logic [2:0]      nmem [NUM_NETS];
	logic            nmem_we;
	logic [NW-1:0]   nmem_wa;
	logic [2:0]      nmem_wd;
	logic [NW-1:0]   nmem_ra;
	logic [2:0]      nmem_rd_q;

	edgs_pkg::gate_t gmem [MAX_GATES];
	logic            gmem_we;
	logic [GW-1:0]   gmem_wa;
	edgs_pkg::gate_t gmem_wd;
	logic [GW-1:0]   gmem_ra;
	edgs_pkg::gate_t grd_q;

	edgs_pkg::event_t qmem [QUEUE_DEPTH];
	logic             qmem_we;
	logic [QW-1:0]    qmem_wa;
	edgs_pkg::event_t qmem_wd;
	logic [QW-1:0]    qmem_ra;
	edgs_pkg::event_t qrd_q;

	edgs_pkg::back_state_t state_q, state_n;
	edgs_pkg::cmd_t   cmd_q, cmd_n;
	logic             error_q, error_n;
	logic [GCW-1:0]   gcount_q, gcount_n;
	logic [QCW-1:0]   qcount_q, qcount_n;
	logic [19:0]      proc_q, proc_n;
	logic [NW-1:0]    clr_q, clr_n;
	logic             clr_reply_q, clr_reply_n;
	logic [QCW-1:0]   scan_q, scan_n;
	logic [QCW-1:0]   bpos_q, bpos_n;
	logic [QCW-1:0]   sh_q, sh_n;
	logic [GCW-1:0]   gi_q, gi_n;
	logic [2:0]       ink_q, ink_n;
	edgs_pkg::eval_acc_t acc_q, acc_n;
	edgs_pkg::event_t best_q, best_n;
	logic [2:0]       res_status_q, res_status_n;
	logic             res_tv_q, res_tv_n;
	logic [31:0]      res_time_q, res_time_n;
	logic [7:0]       res_net_q, res_net_n;
	logic [1:0]       res_lvl_q, res_lvl_n;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic             trace_valid_q;
	logic [31:0]      trace_time_q;
	logic [7:0]       trace_net_q;
	logic [1:0]       trace_level_q;

	logic             out_free;
	logic             out_load;
	logic             take;
	logic [QCW-1:0]   scan_pos;
	logic [QCW-1:0]   pos;
	logic [QCW-1:0]   sh_dec;
	logic [GCW-1:0]   gi_inc;
	logic             reads;
	logic [1:0]       nv;
	logic [32:0]      sum;

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == edgs_pkg::BS_DONE) && out_free;
	assign scan_pos = scan_q - QCW'(1);
	assign sh_dec   = sh_q - QCW'(1);
	assign gi_inc   = gi_q + GCW'(1);
	assign take     = (scan_q == QCW'(1)) || (qrd_q.time_ns < best_q.time_ns);
	assign pos      = take ? scan_pos : bpos_q;
	assign nv       = edgs_pkg::eval_level(grd_q.kind, acc_q);
	assign sum      = {1'b0, best_q.time_ns} + 33'(grd_q.delay);

	always_comb begin
		reads = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (32'(i) < 32'(grd_q.nin) && grd_q.src[i] == best_q.net) reads = 1'b1;
		end
	end

	assign gmem_wd.kind  = cmd_q.kind;
	assign gmem_wd.nin   = cmd_q.nin;
	assign gmem_wd.src   = cmd_q.src;
	assign gmem_wd.dst   = cmd_q.target;
	assign gmem_wd.delay = cmd_q.delay;
	assign gmem_wa       = gcount_q[GW-1:0];

	always_ff @(posedge clk) begin
		if (nmem_we) nmem[nmem_wa] <= nmem_wd;
		nmem_rd_q <= nmem[nmem_ra];
	end

	always_ff @(posedge clk) begin
		if (gmem_we) gmem[gmem_wa] <= gmem_wd;
		grd_q <= gmem[gmem_ra];
	end

	always_ff @(posedge clk) begin
		if (qmem_we) qmem[qmem_wa] <= qmem_wd;
		qrd_q <= qmem[qmem_ra];
	end

	always_comb begin
		state_n      = state_q;
		cmd_n        = cmd_q;
		error_n      = error_q;
		gcount_n     = gcount_q;
		qcount_n     = qcount_q;
		proc_n       = proc_q;
		clr_n        = clr_q;
		clr_reply_n  = clr_reply_q;
		scan_n       = scan_q;
		bpos_n       = bpos_q;
		sh_n         = sh_q;
		gi_n         = gi_q;
		ink_n        = ink_q;
		acc_n        = acc_q;
		best_n       = best_q;
		res_status_n = res_status_q;
		res_tv_n     = res_tv_q;
		res_time_n   = res_time_q;
		res_net_n    = res_net_q;
		res_lvl_n    = res_lvl_q;
		cmd_pop      = 1'b0;
		nmem_we      = 1'b0;
		nmem_wa      = NW'(cmd_q.target);
		nmem_wd      = nmem_rd_q;
		nmem_ra      = NW'(cmd_q.target);
		gmem_we      = 1'b0;
		gmem_ra      = gi_q[GW-1:0];
		qmem_we      = 1'b0;
		qmem_wa      = qcount_q[QW-1:0];
		qmem_wd      = qrd_q;
		qmem_ra      = '0;

		case (state_q)
			edgs_pkg::BS_CLEAR: begin
				nmem_we = 1'b1;
				nmem_wa = clr_q;
				nmem_wd = {1'b0, edgs_pkg::LV_UNK};
				if (clr_q == NW'(NUM_NETS - 1)) begin
					state_n = clr_reply_q ? edgs_pkg::BS_DONE : edgs_pkg::BS_IDLE;
				end else begin
					clr_n = clr_q + NW'(1);
				end
			end
			edgs_pkg::BS_IDLE: begin
				if (cmd_valid) begin
					cmd_pop      = 1'b1;
					cmd_n        = cmd;
					res_status_n = edgs_pkg::ST_OK;
					res_tv_n     = 1'b0;
					res_time_n   = 32'd0;
					res_net_n    = 8'd0;
					res_lvl_n    = 2'd0;
					state_n      = edgs_pkg::BS_DONE;
					if (cmd.op == edgs_pkg::CMD_CLEAR) begin
						gcount_n    = '0;
						qcount_n    = '0;
						proc_n      = 20'd0;
						error_n     = 1'b0;
						clr_n       = '0;
						clr_reply_n = 1'b1;
						state_n     = edgs_pkg::BS_CLEAR;
					end else if (error_q) begin
						res_status_n = edgs_pkg::ST_CFG;
					end else begin
						case (cmd.op)
							edgs_pkg::CMD_LOAD: begin
								if (cmd.load_bad || gcount_q == GCW'(MAX_GATES)) begin
									error_n      = 1'b1;
									res_status_n = edgs_pkg::ST_CFG;
								end else begin
									nmem_ra = NW'(cmd.target);
									state_n = edgs_pkg::BS_LOAD;
								end
							end
							edgs_pkg::CMD_STIM: begin
								if (cmd.stim_bad) begin
									error_n      = 1'b1;
									res_status_n = edgs_pkg::ST_CFG;
								end else if (qcount_q == QCW'(QUEUE_DEPTH)) begin
									res_status_n = edgs_pkg::ST_OVF;
								end else begin
									qmem_we       = 1'b1;
									qmem_wd.time_ns = cmd.time_ns;
									qmem_wd.net   = cmd.target;
									qmem_wd.level = cmd.level;
									qcount_n      = qcount_q + QCW'(1);
								end
							end
							default: begin
								if (qcount_q == '0) begin
									res_status_n = edgs_pkg::ST_EMPTY;
								end else if (proc_q >= event_limit) begin
									res_status_n = edgs_pkg::ST_LIMIT;
								end else begin
									qmem_ra = '0;
									scan_n  = QCW'(1);
									state_n = edgs_pkg::BS_SCAN;
								end
							end
						endcase
					end
				end
			end
			edgs_pkg::BS_LOAD: begin
				state_n = edgs_pkg::BS_DONE;
				if (nmem_rd_q[2]) begin
					error_n      = 1'b1;
					res_status_n = edgs_pkg::ST_CFG;
				end else begin
					gmem_we  = 1'b1;
					nmem_we  = 1'b1;
					nmem_wd  = {1'b1, nmem_rd_q[1:0]};
					gcount_n = gcount_q + GCW'(1);
				end
			end
			edgs_pkg::BS_SCAN: begin
				// Strict compare keeps the oldest of equal times, since entries sit in arrival order.
				best_n = take ? qrd_q : best_q;
				bpos_n = pos;
				if (scan_q < qcount_q) begin
					qmem_ra = scan_q[QW-1:0];
					scan_n  = scan_q + QCW'(1);
				end else begin
					sh_n    = pos + QCW'(1);
					state_n = edgs_pkg::BS_SHRD;
				end
			end
			edgs_pkg::BS_SHRD: begin
				if (sh_q < qcount_q) begin
					qmem_ra = sh_q[QW-1:0];
					state_n = edgs_pkg::BS_SHWR;
				end else begin
					qcount_n = qcount_q - QCW'(1);
					proc_n   = proc_q + 20'd1;
					nmem_ra  = NW'(best_q.net);
					state_n  = edgs_pkg::BS_COMMIT;
				end
			end
			edgs_pkg::BS_SHWR: begin
				qmem_we = 1'b1;
				qmem_wa = sh_dec[QW-1:0];
				qmem_wd = qrd_q;
				sh_n    = sh_q + QCW'(1);
				state_n = edgs_pkg::BS_SHRD;
			end
			edgs_pkg::BS_COMMIT: begin
				if (nmem_rd_q[1:0] == best_q.level) begin
					state_n = edgs_pkg::BS_DONE;
				end else begin
					nmem_we    = 1'b1;
					nmem_wa    = NW'(best_q.net);
					nmem_wd    = {nmem_rd_q[2], best_q.level};
					res_tv_n   = 1'b1;
					res_time_n = best_q.time_ns;
					res_net_n  = best_q.net;
					res_lvl_n  = best_q.level;
					if (gcount_q == '0) begin
						state_n = edgs_pkg::BS_DONE;
					end else begin
						gi_n    = '0;
						gmem_ra = '0;
						state_n = edgs_pkg::BS_GCHK;
					end
				end
			end
			edgs_pkg::BS_GCHK: begin
				if (reads) begin
					nmem_ra = NW'(grd_q.src[0]);
					ink_n   = 3'd1;
					acc_n   = '0;
					state_n = edgs_pkg::BS_IN;
				end else if (gi_inc < gcount_q) begin
					gi_n    = gi_inc;
					gmem_ra = gi_inc[GW-1:0];
				end else begin
					state_n = edgs_pkg::BS_DONE;
				end
			end
			edgs_pkg::BS_IN: begin
				acc_n = edgs_pkg::acc_add(acc_q, nmem_rd_q[1:0]);
				if (ink_q < grd_q.nin) begin
					nmem_ra = NW'(grd_q.src[ink_q[1:0]]);
					ink_n   = ink_q + 3'd1;
				end else begin
					nmem_ra = NW'(grd_q.dst);
					state_n = edgs_pkg::BS_EVAL;
				end
			end
			edgs_pkg::BS_EVAL: begin
				if (nmem_rd_q[1:0] != nv) begin
					if (sum[32]) begin
						res_status_n = edgs_pkg::ST_OVF;
					end else if (qcount_q == QCW'(QUEUE_DEPTH)) begin
						res_status_n = edgs_pkg::ST_OVF;
					end else begin
						qmem_we         = 1'b1;
						qmem_wd.time_ns = sum[31:0];
						qmem_wd.net     = grd_q.dst;
						qmem_wd.level   = nv;
						qcount_n        = qcount_q + QCW'(1);
					end
				end
				if (gi_inc < gcount_q) begin
					gi_n    = gi_inc;
					gmem_ra = gi_inc[GW-1:0];
					state_n = edgs_pkg::BS_GCHK;
				end else begin
					state_n = edgs_pkg::BS_DONE;
				end
			end
			edgs_pkg::BS_DONE: begin
				if (out_free) begin
					clr_reply_n = 1'b0;
					state_n     = edgs_pkg::BS_IDLE;
				end
			end
			default: begin
				state_n = edgs_pkg::BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= edgs_pkg::BS_CLEAR;
			error_q     <= 1'b0;
			gcount_q    <= '0;
			qcount_q    <= '0;
			proc_q      <= 20'd0;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			scan_q      <= '0;
			bpos_q      <= '0;
			sh_q        <= '0;
			gi_q        <= '0;
			ink_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			error_q     <= error_n;
			gcount_q    <= gcount_n;
			qcount_q    <= qcount_n;
			proc_q      <= proc_n;
			clr_q       <= clr_n;
			clr_reply_q <= clr_reply_n;
			scan_q      <= scan_n;
			bpos_q      <= bpos_n;
			sh_q        <= sh_n;
			gi_q        <= gi_n;
			ink_q       <= ink_n;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_n;
		acc_q        <= acc_n;
		best_q       <= best_n;
		res_status_q <= res_status_n;
		res_tv_q     <= res_tv_n;
		res_time_q   <= res_time_n;
		res_net_q    <= res_net_n;
		res_lvl_q    <= res_lvl_n;
		if (out_load) begin
			status_q      <= res_status_q;
			trace_valid_q <= res_tv_q;
			trace_time_q  <= res_time_q;
			trace_net_q   <= res_net_q;
			trace_level_q <= res_lvl_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign trace_valid = trace_valid_q;
	assign trace_time  = trace_time_q;
	assign trace_net   = trace_net_q;
	assign trace_level = trace_level_q;

endmodule

>>> sv/edgs_checker.sv
// Port-level checker for the gate simulator, bound to the top level.
`include "event_driven_gate_simulator_unit_defines.svh"

module edgs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic        trace_valid,
	input logic [31:0] trace_time,
	input logic [7:0]  trace_net,
	input logic [1:0]  trace_level
);

	`EDGS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	// A reported change comes only from a step that popped an event.
	`EDGS_ASSERT_IMP(a_trace_status, out_valid && trace_valid, status == edgs_pkg::ST_OK || status == edgs_pkg::ST_OVF)
	`EDGS_ASSERT_IMP(a_trace_zero, out_valid && !trace_valid, trace_time == 32'd0 && trace_net == 8'd0 && trace_level == 2'd0)
	`EDGS_ASSERT_IMP(a_codes, out_valid, trace_level != 2'd3 && status <= edgs_pkg::ST_OVF)

endmodule

bind event_driven_gate_simulator_unit edgs_checker u_edgs_checker (.*);
